// ----- hdl/deq_pkg.sv -----
// Shared types and constants for the double-ended queue unit.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  // Width of one stored value.
  localparam int unsigned WORD_W = 32;
  // Width of the reported occupancy.
  localparam int unsigned OCC_W  = 5;

  // Request kinds.
  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_REAR  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_REAR   = 2'd3
  } kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_EXEC   = 2'd1,
    ST_RDWAIT = 2'd2
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;    // capture the incoming request
    logic exec;        // execute the captured request
    logic finish_pop;  // read data is valid, deliver the pop result
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pop_ok;  // captured request is a pop of a non-empty deque
    logic full;
    logic empty;
  } dp_stat_t;

endpackage : deq_pkg

`default_nettype wire

// ----- hdl/deq_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule : deq_ram

`default_nettype wire

// ----- hdl/deq_ctrl.sv -----
// Controller state machine of the double-ended queue unit.
// Depends on deq_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire deq_pkg::dp_stat_t    stat,
  output deq_pkg::ctrl_cmd_t        cmd,
  output logic                      busy
);

  import deq_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next-state logic: a successful pop goes through ST_RDWAIT to wait for the read data.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.pop_ok) begin
          state_nxt = ST_RDWAIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RDWAIT: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Output logic.
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy         = 1'b0;
        cmd.load_req = start;
      end
      ST_EXEC:   cmd.exec       = 1'b1;
      ST_RDWAIT: cmd.finish_pop = 1'b1;
      default:   busy           = 1'b1;
    endcase
  end

endmodule : deq_ctrl

`default_nettype wire

// ----- hdl/deq_dp.sv -----
// Datapath of the double-ended queue unit: ring pointers, count, store and
// result registers. Depends on deq_pkg and instantiates deq_ram.
`timescale 1ns / 1ps
`default_nettype none

module deq_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire deq_pkg::ctrl_cmd_t                cmd,
  output deq_pkg::dp_stat_t                      stat,
  input  wire logic [1:0]                        in_kind,
  input  wire logic signed [deq_pkg::WORD_W-1:0] in_push_value,
  output logic                                   out_strobe,
  output logic [1:0]                             out_status,
  output logic signed [deq_pkg::WORD_W-1:0]      out_popped_value,
  output logic [deq_pkg::OCC_W-1:0]              out_occupancy
);

  import deq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  // Captured request.
  kind_t             kind_r;
  logic [WORD_W-1:0] value_r;

  // Ring state.
  logic [AW-1:0] head_r;
  logic [AW-1:0] head_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  // Result registers.
  logic              strobe_r;
  logic              strobe_nxt;
  status_t           status_r;
  status_t           status_nxt;
  logic [WORD_W-1:0] popped_r;
  logic [WORD_W-1:0] popped_nxt;
  logic [OCC_W-1:0]  occ_r;
  logic [OCC_W-1:0]  occ_nxt;

  // Decoded request and ring positions.
  logic          is_push;
  logic          is_front;
  logic          full;
  logic          empty;
  logic          push_ok;
  logic          pop_ok;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] head_inc;
  logic [SW-1:0] tail_sum;
  logic [SW-1:0] rear_sum;
  logic [AW-1:0] tail_pos;
  logic [AW-1:0] rear_pos;

  // RAM ports.
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      kind_r  <= kind_t'(in_kind);
      value_r <= in_push_value;
    end
  end

  // Request decode.
  assign is_push  = (kind_r == KIND_PUSH_FRONT) || (kind_r == KIND_PUSH_REAR);
  assign is_front = (kind_r == KIND_PUSH_FRONT) || (kind_r == KIND_POP_FRONT);
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign push_ok  = is_push && !full;
  assign pop_ok   = !is_push && !empty;

  assign stat.pop_ok = pop_ok;
  assign stat.full   = full;
  assign stat.empty  = empty;

  // Ring position arithmetic, wrapped with one compare and subtract.
  assign head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign tail_sum = SW'(head_r) + SW'(count_r);
  assign rear_sum = tail_sum - SW'(1);
  assign tail_pos = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
  assign rear_pos = (rear_sum >= SW'(DEPTH)) ? AW'(rear_sum - SW'(DEPTH)) : AW'(rear_sum);

  // Store access during execution.
  assign wr_en   = cmd.exec && push_ok;
  assign wr_addr = is_front ? head_dec : tail_pos;
  assign rd_en   = cmd.exec && pop_ok;
  assign rd_addr = is_front ? head_r : rear_pos;

  deq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (value_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Pointer and count update.
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.exec) begin
      if (push_ok) begin
        count_nxt = count_r + CW'(1);
        if (is_front) begin
          head_nxt = head_dec;
        end
      end else if (pop_ok) begin
        count_nxt = count_r - CW'(1);
        if (is_front) begin
          head_nxt = head_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // Result formation: pushes and refused requests finish in execution,
  // successful pops finish once the read data has arrived.
  always_comb begin
    strobe_nxt = 1'b0;
    status_nxt = status_r;
    popped_nxt = popped_r;
    occ_nxt    = occ_r;
    priority if (cmd.finish_pop) begin
      strobe_nxt = 1'b1;
      status_nxt = STATUS_OK;
      popped_nxt = rd_data;
      occ_nxt    = OCC_W'(count_r);
    end else if (cmd.exec && !pop_ok) begin
      strobe_nxt = 1'b1;
      popped_nxt = '0;
      occ_nxt    = OCC_W'(count_nxt);
      if (is_push) begin
        status_nxt = full ? STATUS_OVERFLOW : STATUS_OK;
      end else begin
        status_nxt = STATUS_UNDERFLOW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    popped_r <= popped_nxt;
    occ_r    <= occ_nxt;
  end

  assign out_strobe       = strobe_r;
  assign out_status       = status_r;
  assign out_popped_value = popped_r;
  assign out_occupancy    = occ_r;

endmodule : deq_dp

`default_nettype wire

// ----- hdl/double_ended_queue_unit.sv -----
// Double-ended queue of signed 32-bit values in a ring store of DEPTH entries.
// A push or a refused request strobes its result at the end of execution; a successful
// pop strobes it after ST_RDWAIT, which waits for the registered store read.
// The unit is busy while a request is in flight and takes a new one only when idle.
// Reset clears the head pointer and count (deque empty); the store is not cleared.
// Depends on deq_pkg, deq_ctrl, deq_dp and deq_ram.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        in_kind,
  input  wire logic signed [deq_pkg::WORD_W-1:0] in_push_value,
  output logic                                   out_strobe,
  output logic [1:0]                             out_status,
  output logic signed [deq_pkg::WORD_W-1:0]      out_popped_value,
  output logic [deq_pkg::OCC_W-1:0]              out_occupancy
);

  import deq_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Controller.
  deq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Datapath.
  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_kind          (in_kind),
    .in_push_value    (in_push_value),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_occupancy    (out_occupancy)
  );

  // An accepted request makes the unit busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not make the unit busy");

  // A result only follows a cycle in which the unit was working.
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without a request in flight");

  // An overflow is reported only while the deque is full.
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status == STATUS_OVERFLOW)) |-> stat.full)
    else $error("overflow reported on a deque that is not full");

  // An underflow is reported only while the deque is empty.
  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status == STATUS_UNDERFLOW)) |-> stat.empty)
    else $error("underflow reported on a deque that is not empty");

endmodule : double_ended_queue_unit

`default_nettype wire

// ----- tb/double_ended_queue_unit_test.sv -----
// Self-checking testbench for the double-ended queue unit: random and directed push/pop
// requests with an in-bench predictor of the ring store. Depends on deq_pkg and the unit.
`timescale 1ns / 1ps

module double_ended_queue_unit_test;
  import deq_pkg::*;

  localparam int unsigned QUEUE_DEPTH  = 16;
  localparam int unsigned SLOT_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned RANDOM_COUNT = 600;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 12;

  // One pending request and the gap that follows its acceptance.
  typedef struct {
    kind_t                     kind;
    logic signed [WORD_W-1:0]  value;
    int unsigned               gap;
  } request_t;

  // One predicted reply.
  typedef struct {
    status_t                   status;
    logic signed [WORD_W-1:0]  popped;
    logic [OCC_W-1:0]          occupancy;
  } reply_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [1:0]                  in_kind = KIND_PUSH_FRONT;
  logic signed [WORD_W-1:0]    in_push_value = '0;
  logic                        out_strobe;
  logic [1:0]                  out_status;
  logic signed [WORD_W-1:0]    out_popped_value;
  logic [OCC_W-1:0]            out_occupancy;

  request_t                    request_backlog[$];
  reply_t                      expected_replies[$];

  // Predictor state: ring store, front pointer and fill level.
  logic signed [WORD_W-1:0]    ring_store [QUEUE_DEPTH];
  logic [SLOT_W-1:0]           ring_head = '0;
  logic [OCC_W-1:0]            ring_fill = '0;

  int unsigned                 fail_count = 0;
  int unsigned                 cycle_count = 0;
  int unsigned                 idle_left = 0;
  logic                        accepted;
  request_t                    next_request;

  double_ended_queue_unit #(
    .DEPTH(QUEUE_DEPTH)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_push_value   (in_push_value),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_popped_value(out_popped_value),
    .out_occupancy   (out_occupancy)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Applies one request to the predictor state and returns the reply it should produce.
  function automatic reply_t deque_apply(kind_t kind, logic signed [WORD_W-1:0] value);
    reply_t             r;
    logic [SLOT_W-1:0]  slot;
    r.status = STATUS_OK;
    r.popped = '0;
    if (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_REAR) begin
      if (ring_fill >= QUEUE_DEPTH) begin
        r.status = STATUS_OVERFLOW;
      end else if (kind == KIND_PUSH_FRONT) begin
        ring_head = ring_head - 1'b1;
        ring_store[ring_head] = value;
        ring_fill = ring_fill + 1'b1;
      end else begin
        slot = ring_head + ring_fill[SLOT_W-1:0];
        ring_store[slot] = value;
        ring_fill = ring_fill + 1'b1;
      end
    end else begin
      if (ring_fill == 0) begin
        r.status = STATUS_UNDERFLOW;
      end else if (kind == KIND_POP_FRONT) begin
        r.popped = ring_store[ring_head];
        ring_head = ring_head + 1'b1;
        ring_fill = ring_fill - 1'b1;
      end else begin
        slot = ring_head + ring_fill[SLOT_W-1:0] - 1'b1;
        r.popped = ring_store[slot];
        ring_fill = ring_fill - 1'b1;
      end
    end
    r.occupancy = ring_fill;
    return r;
  endfunction

  // Queues one request for the driver.
  task automatic add_request(kind_t kind, logic signed [WORD_W-1:0] value, int unsigned gap);
    request_t req;
    req.kind  = kind;
    req.value = value;
    req.gap   = gap;
    request_backlog.push_back(req);
  endtask

  // Fully random values half the time, with the extremes and small numbers mixed in.
  function automatic logic signed [WORD_W-1:0] draw_value();
    case ($urandom_range(9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return -32'sd1;
      3:       return 32'sd0;
      4:       return $urandom_range(255);
      default: return $urandom;
    endcase
  endfunction

  // Idle gap after a request; the burst style picks no gaps, short ones or a mix with long.
  function automatic int unsigned draw_gap(int unsigned style);
    int unsigned roll;
    roll = $urandom_range(99);
    if (style == 0) return 0;
    if (roll < 65) return 0;
    if (roll < 93 || style == 1) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Driver: presents the next request, holds it while busy, then idles for its gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      idle_left = 0;
    end else begin
      accepted = start && !busy;
      if (accepted) begin
        expected_replies.push_back(deque_apply(kind_t'(in_kind), in_push_value));
      end
      if (start && !accepted) begin
        start <= 1'b1;
      end else if (idle_left > 0) begin
        start <= 1'b0;
        idle_left--;
      end else if (request_backlog.size() > 0) begin
        next_request = request_backlog.pop_front();
        start <= 1'b1;
        in_kind <= next_request.kind;
        in_push_value <= next_request.value;
        idle_left = next_request.gap;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed reply is compared with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_replies.size() == 0) begin
        $error("reply with no request outstanding: status %0d, popped %0d, occupancy %0d",
               out_status, out_popped_value, out_occupancy);
        fail_count++;
      end else begin
        if (out_status !== expected_replies[0].status) begin
          $error("status mismatch: expected %0d, got %0d",
                 expected_replies[0].status, out_status);
          fail_count++;
        end
        if (out_popped_value !== expected_replies[0].popped) begin
          $error("popped_value mismatch: expected %0d, got %0d",
                 expected_replies[0].popped, out_popped_value);
          fail_count++;
        end
        if (out_occupancy !== expected_replies[0].occupancy) begin
          $error("occupancy mismatch: expected %0d, got %0d",
                 expected_replies[0].occupancy, out_occupancy);
          fail_count++;
        end
        void'(expected_replies.pop_front());
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned issued;
    int unsigned burst_len;
    int unsigned push_pct;
    int unsigned style;
    kind_t       kind;

    // Directed part: underflow on both ends, fill with extremes, overflow on both ends,
    // then one pop from each end of the full deque.
    add_request(KIND_POP_FRONT, 32'sh1234_5678, 0);
    add_request(KIND_POP_REAR, -32'sd1, 1);
    add_request(KIND_PUSH_FRONT, 32'sh7FFF_FFFF, 0);
    add_request(KIND_PUSH_REAR, 32'sh8000_0000, 0);
    add_request(KIND_PUSH_FRONT, -32'sd1, 2);
    add_request(KIND_PUSH_REAR, 32'sd0, 0);
    for (int i = 0; i < 12; i++) begin
      add_request(i[0] ? KIND_PUSH_REAR : KIND_PUSH_FRONT, $urandom, 0);
    end
    add_request(KIND_PUSH_FRONT, 32'sh5555_5555, 0);
    add_request(KIND_PUSH_REAR, 32'shAAAA_AAAA, 3);
    add_request(KIND_POP_REAR, 32'sd0, 0);
    add_request(KIND_POP_FRONT, 32'sd0, 0);

    // Random part in bursts that lean toward filling, draining or churning.
    issued = 0;
    while (issued < RANDOM_COUNT) begin
      burst_len = $urandom_range(60, 10);
      case ($urandom_range(3))
        0:       push_pct = 15;
        1:       push_pct = 85;
        2:       push_pct = 100;
        default: push_pct = 50;
      endcase
      style = $urandom_range(2);
      for (int i = 0; i < burst_len; i++) begin
        if ($urandom_range(99) < 5) begin
          kind = kind_t'($urandom_range(3));
        end else if ($urandom_range(99) < push_pct) begin
          kind = $urandom_range(1) ? KIND_PUSH_REAR : KIND_PUSH_FRONT;
        end else begin
          kind = $urandom_range(1) ? KIND_POP_REAR : KIND_POP_FRONT;
        end
        add_request(kind, $urandom_range(3) == 0 ? $urandom : draw_value(), draw_gap(style));
        issued++;
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    wait (request_backlog.size() == 0 && !start && expected_replies.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && expected_replies.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
